// ===== rtl/core/one_at_a_time_hash_bin_defines.svh =====
// Assertion macros shared by the hash bin checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ONE_AT_A_TIME_HASH_BIN_DEFINES_SVH
`define ONE_AT_A_TIME_HASH_BIN_DEFINES_SVH

// Property that is checked only outside reset.
`define OAH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that also covers the cycles in and right after reset.
`define OAH_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/oah_pkg.sv =====
// Package for the one-at-a-time hash bin block: widths, constants and mix functions.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package oah_pkg;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

   localparam logic [HASH_W-1:0] BIN_COUNT_RESET = 32'd65536;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   localparam int ABSORB_SHL = 10;
   localparam int ABSORB_SHR = 6;
   localparam int FINAL_SHL_A = 3;
   localparam int FINAL_SHR = 11;
   localparam int FINAL_SHL_B = 15;

   typedef logic [HASH_W-1:0] hash_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Adds one zero-extended byte and runs the per-byte mix.
   function automatic hash_type absorb_byte(hash_type h, logic [BYTE_W-1:0] b);
      hash_type t;
      t = h + {{(HASH_W-BYTE_W){1'b0}}, b};
      t = t + (t << ABSORB_SHL);
      t = t ^ (t >> ABSORB_SHR);
      return t;
   endfunction

   // Final avalanche applied after the last byte.
   function automatic hash_type finish_hash(hash_type h);
      hash_type t;
      t = h + (h << FINAL_SHL_A);
      t = t ^ (t >> FINAL_SHR);
      t = t + (t << FINAL_SHL_B);
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/oah_front.sv =====
// Front end: takes key bytes and keeps the running hash of the current key.
// Depends on oah_pkg; hands the absorbed hash of each finished key to the queue.
`timescale 1ns / 1ps
`default_nettype none

module oah_front
   import oah_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_key_byte,
   input  wire logic                  req_last_byte,
   input  wire fifo_status_type       fifo_status,
   output logic                       push,
   output hash_type                   push_data
);

   hash_type hash_ff;
   hash_type hash_in;
   hash_type absorbed;
   logic     accept;

   assign req_ready = !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign absorbed  = absorb_byte(hash_ff, req_key_byte);

   assign push      = accept && req_last_byte;
   assign push_data = absorbed;

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         // The accumulator restarts from zero once a key is complete.
         hash_in = req_last_byte ? '0 : absorbed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/oah_fifo.sv =====
// Two-entry queue between the byte front end and the finishing back end.
// Depends on oah_pkg for the entry type and depth constants.
`timescale 1ns / 1ps
`default_nettype none

module oah_fifo
   import oah_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire hash_type    push_data,
   input  wire logic        pop,
   output hash_type         pop_data,
   output fifo_status_type  status
);

   hash_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/oah_back.sv =====
// Back end: final mix, bit-serial reduction modulo the bin count, result register.
// Depends on oah_pkg; takes finished keys from the queue one at a time.
`timescale 1ns / 1ps
`default_nettype none

module oah_back
   import oah_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire hash_type         bin_count,
   input  wire fifo_status_type  fifo_status,
   input  wire hash_type         pop_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [HASH_W-1:0]     rsp_bin_index,
   output logic [HASH_W-1:0]     rsp_full_hash
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   hash_type          hash_ff;
   hash_type          hash_in;
   hash_type          dividend_ff;
   hash_type          dividend_in;
   hash_type          rem_ff;
   hash_type          rem_in;
   hash_type          divisor_ff;
   hash_type          divisor_in;
   hash_type          finished;
   logic [HASH_W:0]   trial;
   logic [HASH_W:0]   diff;

   assign finished = finish_hash(hash_ff);

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign trial = {rem_ff, dividend_ff[HASH_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   assign pop           = (state_ff == ST_IDLE) && !fifo_status.empty;
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_bin_index = rem_ff;
   assign rsp_full_hash = hash_ff;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      hash_in     = hash_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_status.empty) begin
               hash_in  = pop_data;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            hash_in     = finished;
            dividend_in = finished;
            rem_in      = '0;
            step_in     = '0;
            // A zero bin count behaves as a single bin.
            divisor_in  = (bin_count == '0) ? HASH_W'(1) : bin_count;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            rem_in      = diff[HASH_W] ? trial[HASH_W-1:0] : diff[HASH_W-1:0];
            dividend_in = dividend_ff << 1;
            step_in     = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/one_at_a_time_hash_bin.sv =====
// Top level of the one-at-a-time hash bin block.
// Depends on oah_pkg, oah_front, oah_fifo and oah_back.
`timescale 1ns / 1ps
`default_nettype none

// Key bytes stream in at one per cycle while the queue is not full; each byte is
// zero-extended and mixed into a 32-bit running hash, and the byte flagged as last
// closes the key. A finished key waits in a two-entry queue, and the back end then
// handles one key at a time: it takes the key from the queue, applies the final mix,
// runs the bit-serial remainder unit and offers the result on the rsp channel until
// it is taken. When the back end falls behind the byte stream, the front end keeps
// taking bytes until the queue is full. bin_index is full_hash modulo the bin count,
// which resets to 65536; a count of zero acts as one. Write the bin count only while
// no key is in flight.
module one_at_a_time_hash_bin
   import oah_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [BYTE_W-1:0]   req_key_byte,
   input  wire logic                req_last_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [HASH_W-1:0]        rsp_bin_index,
   output logic [HASH_W-1:0]        rsp_full_hash,
   input  wire logic                csr_wr_en,
   input  wire logic [HASH_W-1:0]   csr_wr_data
);

   hash_type        bin_count_ff;
   hash_type        bin_count_in;
   fifo_status_type fifo_status;
   logic            push;
   hash_type        push_data;
   logic            pop;
   hash_type        pop_data;

   assign bin_count_in = csr_wr_en ? csr_wr_data : bin_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_COUNT_RESET;
      end else begin
         bin_count_ff <= bin_count_in;
      end
   end

   oah_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key_byte  (req_key_byte),
      .req_last_byte (req_last_byte),
      .fifo_status   (fifo_status),
      .push          (push),
      .push_data     (push_data)
   );

   oah_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   oah_back u_back (
      .clock         (clock),
      .reset         (reset),
      .bin_count     (bin_count_ff),
      .fifo_status   (fifo_status),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_full_hash (rsp_full_hash)
   );

endmodule

`default_nettype wire

// ===== rtl/core/oah_checker.sv =====
// Port-level checker for the one-at-a-time hash bin block, bound to the top level.
// Depends on oah_pkg and the assertion macros in one_at_a_time_hash_bin_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "one_at_a_time_hash_bin_defines.svh"

module oah_checker
   import oah_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [BYTE_W-1:0]   req_key_byte,
   input wire logic                req_last_byte,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [HASH_W-1:0]   rsp_bin_index,
   input wire logic [HASH_W-1:0]   rsp_full_hash,
   input wire logic                csr_wr_en,
   input wire logic [HASH_W-1:0]   csr_wr_data
);

   hash_type            bin_count_ff;
   hash_type            bin_count_in;
   logic                index_in_range;
   logic [BYTE_W:0]     req_payload;

   // Mirror of the bin count as written through the register port.
   assign bin_count_in = csr_wr_en ? csr_wr_data : bin_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_COUNT_RESET;
      end else begin
         bin_count_ff <= bin_count_in;
      end
   end

   assign index_in_range = (bin_count_ff == '0) ? (rsp_bin_index == '0)
                                                : (rsp_bin_index < bin_count_ff);
   assign req_payload = {req_key_byte, req_last_byte};

   `OAH_ASSERT_RST(a_idle_after_reset, reset |=> !rsp_valid, "result offered right after reset")
   `OAH_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index) && $stable(rsp_full_hash), "stalled result changed")
   `OAH_ASSERT(a_index_range, rsp_valid |-> index_in_range, "bin index not below bin count")
   `OAH_ASSERT(a_req_held, req_valid && !req_ready |=> req_valid && $stable(req_payload), "waiting request changed")

endmodule

bind one_at_a_time_hash_bin oah_checker u_oah_checker (.*);

`default_nettype wire
